// ----- hw/rtl/cfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants of the crc32 frame receiver
// Register indexes, result codes, configuration bundle and result bundle.
// ----------------------------------------------------------------------------
package cfr_pkg;

    // largest payload the receiver ever takes, whatever max_payload says
    localparam int MAX_PAYLOAD_BYTES = 512;
    localparam int LEFT_W            = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_FIRST    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_SECOND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_FIRST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_SECOND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_FINAL_XOR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_REFLECTED = 3'd7;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // reject reasons
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_LENGTH = 2'd1;
    localparam logic [1:0] ERR_CRC    = 2'd2;
    localparam logic [1:0] ERR_TAIL   = 2'd3;

    localparam logic [15:0] HI_BYTE_MASK = 16'hff00;

    typedef struct packed {
        logic [7:0]        head_first;
        logic [7:0]        head_second;
        logic [7:0]        tail_first;
        logic [7:0]        tail_second;
        logic [LEFT_W-1:0] max_payload;
        logic [31:0]       crc_init;
        logic [31:0]       crc_final_xor;
        logic              crc_reflected;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [15:0] function_code;
        logic [15:0] received_length;
        logic [1:0]  error_code;
    } t_result;

endpackage

// ----- hw/rtl/cfr_byte_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_byte_if: received byte channel
// Valid/ready channel that carries one link byte per item.
// ----------------------------------------------------------------------------
interface cfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hw/rtl/cfr_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_result_if: result channel
// Valid/ready channel that carries one payload byte or frame verdict per item.
// ----------------------------------------------------------------------------
interface cfr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] function_code;
    logic [15:0] received_length;
    logic [1:0]  error_code;

    modport source (output valid, output kind, output payload_byte, output function_code,
                    output received_length, output error_code, input ready);
    modport sink   (input valid, input kind, input payload_byte, input function_code,
                    input received_length, input error_code, output ready);
endinterface

// ----- hw/rtl/crc32_frame_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_frame_receiver: byte-serial framed packet receiver with crc-32 check
//
// Bytes enter on i_in (valid/ready) and are taken into an input register.
// The parser takes it once the result slot is free, advances the frame state,
// folds the byte into the crc, and may load one result item into the output
// register, which drives o_out (valid/ready). Payload bytes stream out as
// kind 0; every frame that gets past its head ends in one accept or reject.
// Throughput is one byte per cycle while o_out does not stall, set by the
// combinational parse and byte-wide crc path between the input and output
// registers. When o_out stalls with a result waiting, the parser holds and
// the input register fills; i_in.ready then drops until the consumer takes
// the result. Bytes that give no result never wait on the consumer beyond that.
// Reset (i_rst_n low, synchronous) empties both registers, puts the parser
// back to hunting the first head byte and loads configuration defaults.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// writes it only with the block idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module crc32_frame_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cfr_byte_if.sink                       i_in,
    cfr_result_if.source                   o_out
);
    import cfr_pkg::*;

    t_cfg    w_cfg;
    t_result w_res;
    logic    w_res_valid;
    logic    w_free;
    logic    w_fire;
    logic    r_in_valid;
    logic [7:0] r_in_byte;

    cfr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // input register: the parser drains it whenever the result slot is free
    assign w_fire     = r_in_valid && w_free;
    assign i_in.ready = !r_in_valid || w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.rx_byte;
        end
    end

    cfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_fire      (w_fire),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    cfr_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_fire),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_free      (w_free),
        .o_out       (o_out)
    );

endmodule

// ----- hw/rtl/cfr_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_cfg_regs: configuration register file
// Write-only registers for head/tail bytes, payload limit and crc options.
// ----------------------------------------------------------------------------
module cfr_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output cfr_pkg::t_cfg                 o_cfg
);
    import cfr_pkg::*;

    t_cfg r_cfg;

    // register writes, decoded by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_first    <= 8'haa;
            r_cfg.head_second   <= 8'h55;
            r_cfg.tail_first    <= 8'h55;
            r_cfg.tail_second   <= 8'haa;
            r_cfg.max_payload   <= LEFT_W'(MAX_PAYLOAD_BYTES);
            r_cfg.crc_init      <= 32'hffff_ffff;
            r_cfg.crc_final_xor <= 32'hffff_ffff;
            r_cfg.crc_reflected <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HEAD_FIRST:    r_cfg.head_first    <= i_cfg_data[7:0];
                REG_HEAD_SECOND:   r_cfg.head_second   <= i_cfg_data[7:0];
                REG_TAIL_FIRST:    r_cfg.tail_first    <= i_cfg_data[7:0];
                REG_TAIL_SECOND:   r_cfg.tail_second   <= i_cfg_data[7:0];
                REG_MAX_PAYLOAD:   r_cfg.max_payload   <= i_cfg_data[LEFT_W-1:0];
                REG_CRC_INIT:      r_cfg.crc_init      <= i_cfg_data[31:0];
                REG_CRC_FINAL_XOR: r_cfg.crc_final_xor <= i_cfg_data[31:0];
                REG_CRC_REFLECTED: r_cfg.crc_reflected <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/cfr_crc_byte.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_crc_byte: byte-wide crc-32 update
// One byte into the crc register, polynomial 0x04C11DB7, either bit order.
// ----------------------------------------------------------------------------
module cfr_crc_byte (
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    input  logic        i_reflected,
    output logic [31:0] o_crc
);
    localparam logic [31:0] POLY_NORMAL    = 32'h04c1_1db7;
    localparam logic [31:0] POLY_REFLECTED = 32'hedb8_8320;

    logic [31:0] v_refl;
    logic [31:0] v_norm;

    // eight shift steps unrolled into an xor network, one per bit order
    always_comb begin
        v_refl = i_crc ^ {24'd0, i_byte};
        v_norm = i_crc ^ {i_byte, 24'd0};
        for (int k = 0; k < 8; k++) begin
            v_refl = v_refl[0] ? ((v_refl >> 1) ^ POLY_REFLECTED) : (v_refl >> 1);
            v_norm = v_norm[31] ? ((v_norm << 1) ^ POLY_NORMAL) : (v_norm << 1);
        end
    end

    assign o_crc = i_reflected ? v_refl : v_norm;

endmodule

// ----- hw/rtl/cfr_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_parser: frame parse state machine
// Walks head, code, length, payload, crc and tail; keeps the running crc
// and builds at most one result for each byte it takes.
// ----------------------------------------------------------------------------
module cfr_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfr_pkg::t_cfg     i_cfg,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output cfr_pkg::t_result  o_res
);
    import cfr_pkg::*;

    localparam logic [3:0] PH_HEAD1   = 4'd0;
    localparam logic [3:0] PH_HEAD2   = 4'd1;
    localparam logic [3:0] PH_CODE_HI = 4'd2;
    localparam logic [3:0] PH_CODE_LO = 4'd3;
    localparam logic [3:0] PH_LEN_HI  = 4'd4;
    localparam logic [3:0] PH_LEN_LO  = 4'd5;
    localparam logic [3:0] PH_DATA    = 4'd6;
    localparam logic [3:0] PH_CRC0    = 4'd7;
    localparam logic [3:0] PH_CRC1    = 4'd8;
    localparam logic [3:0] PH_CRC2    = 4'd9;
    localparam logic [3:0] PH_CRC3    = 4'd10;
    localparam logic [3:0] PH_TAIL1   = 4'd11;
    localparam logic [3:0] PH_TAIL2   = 4'd12;

    logic [3:0]        r_phase,  n_phase;
    logic [15:0]       r_code,   n_code;
    logic [15:0]       r_len,    n_len;
    logic [LEFT_W-1:0] r_left,   n_left;
    logic [31:0]       r_crc,    n_crc;
    logic [31:0]       r_crc_rx, n_crc_rx;

    logic [31:0]       v_crc_in;
    logic [31:0]       v_crc_upd;
    logic [31:0]       v_crc_rx_sh;
    logic [LEFT_W-1:0] v_limit;
    logic [LEFT_W-1:0] v_left_dec;
    logic [1:0]        v_kind;
    logic [1:0]        v_err;
    logic [7:0]        v_pay;

    // crc source: a new frame starts from the init register
    assign v_crc_in = (r_phase == PH_HEAD1) ? i_cfg.crc_init : r_crc;

    cfr_crc_byte u_crc (
        .i_crc       (v_crc_in),
        .i_byte      (i_byte),
        .i_reflected (i_cfg.crc_reflected),
        .o_crc       (v_crc_upd)
    );

    assign v_limit     = (i_cfg.max_payload < LEFT_W'(MAX_PAYLOAD_BYTES))
                       ? i_cfg.max_payload : LEFT_W'(MAX_PAYLOAD_BYTES);
    assign v_left_dec  = r_left - LEFT_W'(1);
    assign v_crc_rx_sh = {r_crc_rx[23:0], i_byte};

    // next state and result for the byte on hand
    always_comb begin
        n_phase     = r_phase;
        n_code      = r_code;
        n_len       = r_len;
        n_left      = r_left;
        n_crc       = r_crc;
        n_crc_rx    = r_crc_rx;
        o_res_valid = 1'b0;
        v_kind      = KIND_PAYLOAD;
        v_err       = ERR_NONE;
        v_pay       = 8'd0;
        unique case (r_phase) inside
            PH_HEAD1: begin
                if (i_byte == i_cfg.head_first) begin
                    n_code   = 16'd0;
                    n_len    = 16'd0;
                    n_crc_rx = 32'd0;
                    n_left   = '0;
                    n_crc    = v_crc_upd;
                    n_phase  = PH_HEAD2;
                end
            end
            PH_HEAD2: begin
                if (i_byte == i_cfg.head_second) begin
                    n_crc   = v_crc_upd;
                    n_phase = PH_CODE_HI;
                end else begin
                    n_phase = PH_HEAD1;
                end
            end
            PH_CODE_HI: begin
                n_code  = {i_byte, 8'd0};
                n_crc   = v_crc_upd;
                n_phase = PH_CODE_LO;
            end
            PH_CODE_LO: begin
                n_code  = (r_code & HI_BYTE_MASK) | {8'd0, i_byte};
                n_crc   = v_crc_upd;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = {i_byte, 8'd0};
                n_crc   = v_crc_upd;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len = (r_len & HI_BYTE_MASK) | {8'd0, i_byte};
                n_crc = v_crc_upd;
                if (n_len == 16'd0 || n_len > {{(16-LEFT_W){1'b0}}, v_limit}) begin
                    n_phase     = PH_HEAD1;
                    o_res_valid = 1'b1;
                    v_kind      = KIND_REJECT;
                    v_err       = ERR_LENGTH;
                end else begin
                    n_left  = n_len[LEFT_W-1:0];
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_crc       = v_crc_upd;
                n_left      = v_left_dec;
                o_res_valid = 1'b1;
                v_kind      = KIND_PAYLOAD;
                v_pay       = i_byte;
                if (v_left_dec == '0) begin
                    n_phase = PH_CRC0;
                end
            end
            [PH_CRC0:PH_CRC2]: begin
                n_crc_rx = v_crc_rx_sh;
                n_phase  = r_phase + 4'd1;
            end
            PH_CRC3: begin
                n_crc_rx = v_crc_rx_sh;
                if ((r_crc ^ i_cfg.crc_final_xor) != v_crc_rx_sh) begin
                    n_phase     = PH_HEAD1;
                    o_res_valid = 1'b1;
                    v_kind      = KIND_REJECT;
                    v_err       = ERR_CRC;
                end else begin
                    n_phase = PH_TAIL1;
                end
            end
            PH_TAIL1: begin
                if (i_byte != i_cfg.tail_first) begin
                    n_phase     = PH_HEAD1;
                    o_res_valid = 1'b1;
                    v_kind      = KIND_REJECT;
                    v_err       = ERR_TAIL;
                end else begin
                    n_phase = PH_TAIL2;
                end
            end
            PH_TAIL2: begin
                n_phase     = PH_HEAD1;
                o_res_valid = 1'b1;
                if (i_byte != i_cfg.tail_second) begin
                    v_kind = KIND_REJECT;
                    v_err  = ERR_TAIL;
                end else begin
                    v_kind = KIND_ACCEPT;
                end
            end
            default: begin
                n_phase = PH_HEAD1;
            end
        endcase
    end

    assign o_res.kind            = v_kind;
    assign o_res.payload_byte    = v_pay;
    assign o_res.function_code   = n_code;
    assign o_res.received_length = n_len;
    assign o_res.error_code      = v_err;

    // parse state, advanced once per byte taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEAD1;
            r_code   <= 16'd0;
            r_len    <= 16'd0;
            r_left   <= '0;
            r_crc    <= 32'hffff_ffff;
            r_crc_rx <= 32'd0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_code   <= n_code;
            r_len    <= n_len;
            r_left   <= n_left;
            r_crc    <= n_crc;
            r_crc_rx <= n_crc_rx;
        end
    end

endmodule

// ----- hw/rtl/cfr_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_out_stage: result register
// Holds one result item for the consumer; frees itself as it is taken.
// ----------------------------------------------------------------------------
module cfr_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_res_valid,
    input  cfr_pkg::t_result  i_res,
    output logic              o_free,
    cfr_result_if.source      o_out
);
    import cfr_pkg::*;

    logic    r_valid;
    t_result r_res;

    // slot can be refilled when empty or emptying this cycle
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_res_valid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.kind            = r_res.kind;
    assign o_out.payload_byte    = r_res.payload_byte;
    assign o_out.function_code   = r_res.function_code;
    assign o_out.received_length = r_res.received_length;
    assign o_out.error_code      = r_res.error_code;

endmodule

// ----- test/crc32_frame_receiver_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_frame_receiver_tb: self-checking bench for the crc32 frame receiver
// Streams link bytes into the receiver and checks every result item against
// a cycle-free frame parser kept in the bench. The stimulus is built from
// well-formed frames with random content, broken frames (bad length, crc,
// tail, head) and noise. It runs under several register settings, including
// a write in the middle of a frame, with random stalls on both channels.
// ----------------------------------------------------------------------------
module crc32_frame_receiver_tb;
    import cfr_pkg::*;

    localparam int          IDLE_PCT       = 29;
    localparam int          STALL_LIMIT    = 2000;
    localparam int          PIPE_SETTLE    = 4;
    localparam logic [31:0] POLY_NORMAL    = 32'h04C1_1DB7;
    localparam logic [31:0] POLY_REFLECTED = 32'hEDB8_8320;

    typedef enum logic [3:0] {
        PH_HUNT1, PH_HUNT2, PH_CODE_HI, PH_CODE_LO, PH_LEN_HI, PH_LEN_LO, PH_DATA,
        PH_CRC0, PH_CRC1, PH_CRC2, PH_CRC3, PH_TAIL1, PH_TAIL2
    } t_phase;

    typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_TAIL1, FLAW_TAIL2} t_flaw;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cfr_byte_if   link_if ();
    cfr_result_if res_if ();

    crc32_frame_receiver dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (link_if),
        .o_out      (res_if)
    );

    // register shadow and frame parser state
    t_cfg        cfg;
    t_phase      fr_phase;
    logic [15:0] fr_code;
    logic [15:0] fr_length;
    logic [LEFT_W-1:0] fr_left;
    logic [31:0] fr_crc;
    logic [31:0] fr_crc_rx;

    logic [7:0]  link_bytes[$];
    logic [7:0]  frame_bytes[$];
    t_result     due_results[$];

    logic        byte_taken;
    logic        hold_sender;
    logic        steady;
    int          mismatches;
    int          stall_cycles;
    int          pushed_bytes;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // byte-wide crc update, either bit order
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b,
                                             input logic refl);
        logic [31:0] c;
        c = crc;
        if (refl) begin
            c = c ^ {24'd0, b};
            for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ POLY_REFLECTED) : (c >> 1);
        end else begin
            c = c ^ {b, 24'd0};
            for (int i = 0; i < 8; i++) c = c[31] ? ((c << 1) ^ POLY_NORMAL) : (c << 1);
        end
        return c;
    endfunction

    function automatic int payload_limit();
        return (int'(cfg.max_payload) < MAX_PAYLOAD_BYTES) ? int'(cfg.max_payload)
                                                           : MAX_PAYLOAD_BYTES;
    endfunction

    task automatic reset_model();
        cfg.head_first    = 8'hAA;
        cfg.head_second   = 8'h55;
        cfg.tail_first    = 8'h55;
        cfg.tail_second   = 8'hAA;
        cfg.max_payload   = 10'd512;
        cfg.crc_init      = 32'hFFFF_FFFF;
        cfg.crc_final_xor = 32'hFFFF_FFFF;
        cfg.crc_reflected = 1'b1;
        fr_phase  = PH_HUNT1;
        fr_code   = '0;
        fr_length = '0;
        fr_left   = '0;
        fr_crc    = 32'hFFFF_FFFF;
        fr_crc_rx = '0;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_HEAD_FIRST:    cfg.head_first    = data[7:0];
            REG_HEAD_SECOND:   cfg.head_second   = data[7:0];
            REG_TAIL_FIRST:    cfg.tail_first    = data[7:0];
            REG_TAIL_SECOND:   cfg.tail_second   = data[7:0];
            REG_MAX_PAYLOAD:   cfg.max_payload   = data[LEFT_W-1:0];
            REG_CRC_INIT:      cfg.crc_init      = data;
            REG_CRC_FINAL_XOR: cfg.crc_final_xor = data;
            REG_CRC_REFLECTED: cfg.crc_reflected = data[0];
            default: ;
        endcase
    endtask

    task automatic await_result(input logic [1:0] kind, input logic [7:0] b,
                                input logic [1:0] err);
        due_results.push_back('{kind: kind, payload_byte: b, function_code: fr_code,
                                received_length: fr_length, error_code: err});
    endtask

    // one link byte through the frame parser
    task automatic parse_byte(input logic [7:0] b);
        case (fr_phase) inside
            PH_HUNT1: begin
                if (b == cfg.head_first) begin
                    fr_code   = '0;
                    fr_length = '0;
                    fr_crc_rx = '0;
                    fr_left   = '0;
                    fr_crc    = crc_fold(cfg.crc_init, b, cfg.crc_reflected);
                    fr_phase  = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                if (b == cfg.head_second) begin
                    fr_crc   = crc_fold(fr_crc, b, cfg.crc_reflected);
                    fr_phase = PH_CODE_HI;
                end else begin
                    fr_phase = PH_HUNT1;
                end
            end
            PH_CODE_HI: begin
                fr_code  = {b, 8'h00};
                fr_crc   = crc_fold(fr_crc, b, cfg.crc_reflected);
                fr_phase = PH_CODE_LO;
            end
            PH_CODE_LO: begin
                fr_code[7:0] = b;
                fr_crc   = crc_fold(fr_crc, b, cfg.crc_reflected);
                fr_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                fr_length = {b, 8'h00};
                fr_crc    = crc_fold(fr_crc, b, cfg.crc_reflected);
                fr_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                fr_length[7:0] = b;
                fr_crc = crc_fold(fr_crc, b, cfg.crc_reflected);
                if (fr_length == 16'd0 || int'(fr_length) > payload_limit()) begin
                    fr_phase = PH_HUNT1;
                    await_result(KIND_REJECT, 8'h00, ERR_LENGTH);
                end else begin
                    fr_left  = fr_length[LEFT_W-1:0];
                    fr_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                fr_crc  = crc_fold(fr_crc, b, cfg.crc_reflected);
                fr_left = fr_left - 1'b1;
                if (fr_left == '0) fr_phase = PH_CRC0;
                await_result(KIND_PAYLOAD, b, ERR_NONE);
            end
            [PH_CRC0:PH_CRC2]: begin
                fr_crc_rx = {fr_crc_rx[23:0], b};
                fr_phase  = t_phase'(fr_phase + 1'b1);
            end
            PH_CRC3: begin
                fr_crc_rx = {fr_crc_rx[23:0], b};
                if ((fr_crc ^ cfg.crc_final_xor) != fr_crc_rx) begin
                    fr_phase = PH_HUNT1;
                    await_result(KIND_REJECT, 8'h00, ERR_CRC);
                end else begin
                    fr_phase = PH_TAIL1;
                end
            end
            PH_TAIL1: begin
                if (b != cfg.tail_first) begin
                    fr_phase = PH_HUNT1;
                    await_result(KIND_REJECT, 8'h00, ERR_TAIL);
                end else begin
                    fr_phase = PH_TAIL2;
                end
            end
            PH_TAIL2: begin
                fr_phase = PH_HUNT1;
                if (b != cfg.tail_second) await_result(KIND_REJECT, 8'h00, ERR_TAIL);
                else await_result(KIND_ACCEPT, 8'h00, ERR_NONE);
            end
            default: fr_phase = PH_HUNT1;
        endcase
    endtask

    task automatic report_fault(input string what);
        if (mismatches < 10) $display("[%0t] %s", $realtime, what);
        mismatches++;
    endtask

    // compare the result item on the output against the oldest expectation
    task automatic check_result();
        t_result want;
        if (due_results.size() == 0) begin
            report_fault($sformatf("result with none due: kind %0d byte %02h code %04h len %04h err %0d",
                                   res_if.kind, res_if.payload_byte, res_if.function_code,
                                   res_if.received_length, res_if.error_code));
        end else begin
            want = due_results.pop_front();
            if (res_if.kind !== want.kind || res_if.payload_byte !== want.payload_byte ||
                res_if.function_code !== want.function_code ||
                res_if.received_length !== want.received_length ||
                res_if.error_code !== want.error_code) begin
                report_fault($sformatf({"mismatch: kind %0d/%0d byte %02h/%02h code %04h/%04h ",
                                        "len %04h/%04h err %0d/%0d (expected/actual)"},
                                       want.kind, res_if.kind, want.payload_byte,
                                       res_if.payload_byte, want.function_code,
                                       res_if.function_code, want.received_length,
                                       res_if.received_length, want.error_code,
                                       res_if.error_code));
            end
        end
    endtask

    // monitor: both handshakes, register writes and the stall watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            byte_taken   <= 1'b0;
            stall_cycles = 0;
        end else begin
            if (i_cfg_we) apply_reg(i_cfg_idx, i_cfg_data);
            if (res_if.valid && res_if.ready) check_result();
            if (link_if.valid && link_if.ready) parse_byte(link_if.rx_byte);
            byte_taken <= link_if.valid && link_if.ready;
            if ((res_if.valid && res_if.ready) || (link_if.valid && link_if.ready) || i_cfg_we) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[%0t] no progress for %0d cycles", $realtime, STALL_LIMIT);
                $display("** crc32_frame_receiver: FAILED **");
                $finish;
            end
        end
    end

    // driver: next link byte and result back-pressure, off the falling edge
    always @(negedge i_clk) begin
        if (!link_if.valid || byte_taken) begin
            if (i_rst_n && link_bytes.size() != 0 && !hold_sender &&
                (steady || $urandom_range(99) >= IDLE_PCT)) begin
                link_if.valid   <= 1'b1;
                link_if.rx_byte <= link_bytes.pop_front();
            end else begin
                link_if.valid <= 1'b0;
            end
        end
        res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic queue_byte(input logic [7:0] b);
        link_bytes.push_back(b);
        pushed_bytes++;
    endtask

    // frame with random payload under the current settings, into frame_bytes
    task automatic make_frame(input logic [15:0] code, input int len, input t_flaw flaw);
        logic [15:0] len16;
        logic [31:0] crc;
        logic [7:0]  tail;
        len16 = len[15:0];
        frame_bytes.delete();
        frame_bytes.push_back(cfg.head_first);
        frame_bytes.push_back(cfg.head_second);
        frame_bytes.push_back(code[15:8]);
        frame_bytes.push_back(code[7:0]);
        frame_bytes.push_back(len16[15:8]);
        frame_bytes.push_back(len16[7:0]);
        for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
        crc = cfg.crc_init;
        foreach (frame_bytes[i]) crc = crc_fold(crc, frame_bytes[i], cfg.crc_reflected);
        crc = crc ^ cfg.crc_final_xor;
        if (flaw == FLAW_CRC) crc = crc ^ (32'd1 << $urandom_range(31));
        frame_bytes.push_back(crc[31:24]);
        frame_bytes.push_back(crc[23:16]);
        frame_bytes.push_back(crc[15:8]);
        frame_bytes.push_back(crc[7:0]);
        tail = cfg.tail_first;
        if (flaw == FLAW_TAIL1) tail = tail ^ 8'($urandom_range(1, 255));
        frame_bytes.push_back(tail);
        tail = cfg.tail_second;
        if (flaw == FLAW_TAIL2) tail = tail ^ 8'($urandom_range(1, 255));
        frame_bytes.push_back(tail);
    endtask

    task automatic send_bytes(input int from, input int upto);
        for (int i = from; i < upto; i++) queue_byte(frame_bytes[i]);
    endtask

    task automatic send_frame(input logic [15:0] code, input int len, input t_flaw flaw);
        make_frame(code, len, flaw);
        send_bytes(0, frame_bytes.size());
    endtask

    // head, code and a length the receiver must refuse
    task automatic send_bad_length(input logic [15:0] code, input logic [15:0] len16);
        queue_byte(cfg.head_first);
        queue_byte(cfg.head_second);
        queue_byte(code[15:8]);
        queue_byte(code[7:0]);
        queue_byte(len16[15:8]);
        queue_byte(len16[7:0]);
    endtask

    task automatic send_bad_head();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == cfg.head_second) b = b ^ 8'h01;
        queue_byte(cfg.head_first);
        queue_byte(b);
    endtask

    // mostly well-formed frames, with broken frames and noise mixed in
    task automatic random_traffic(input int budget);
        int    stop_at;
        int    pick;
        int    lim;
        int    len;
        t_flaw flaw;
        stop_at = pushed_bytes + budget;
        lim = payload_limit();
        while (pushed_bytes < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
            end else if (pick < 16) begin
                case ($urandom_range(2))
                    0: send_bad_length(16'($urandom), 16'd0);
                    1: send_bad_length(16'($urandom), 16'(lim + 1));
                    default: send_bad_length(16'($urandom), 16'($urandom_range(lim + 1, 65535)));
                endcase
            end else if (pick < 20) begin
                send_bad_head();
            end else begin
                pick = $urandom_range(99);
                flaw = (pick < 8) ? FLAW_CRC : (pick < 13) ? FLAW_TAIL1 :
                       (pick < 18) ? FLAW_TAIL2 : FLAW_NONE;
                if ($urandom_range(29) == 0) len = $urandom_range(1, (lim < 64) ? lim : 64);
                else len = $urandom_range(1, (lim < 12) ? lim : 12);
                send_frame(16'($urandom), len, flaw);
            end
        end
    endtask

    // wait until the receiver has nothing left in flight
    task automatic settle();
        while (link_bytes.size() != 0 || link_if.valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // stimulus sequence
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        link_if.valid   = 1'b0;
        link_if.rx_byte = 8'h00;
        res_if.ready    = 1'b0;
        hold_sender     = 1'b0;
        steady          = 1'b0;
        mismatches      = 0;
        pushed_bytes    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default settings: corner frames first
        send_frame(16'h0000, 1, FLAW_NONE);
        send_frame(16'hFFFF, 3, FLAW_NONE);
        send_bad_length(16'h1234, 16'd0);
        send_bad_length(16'h8001, 16'd513);
        send_bad_length(16'h00FF, 16'hFFFF);
        send_frame(16'h5AA5, 2, FLAW_CRC);
        send_frame(16'hA55A, 1, FLAW_TAIL1);
        send_frame(16'h0F0F, 1, FLAW_TAIL2);
        send_bad_head();
        // repeated first head byte is not taken as a new start
        queue_byte(cfg.head_first);
        send_frame(16'h7E81, 2, FLAW_NONE);
        random_traffic(100);

        // sender holds off until every due result is out
        while (link_bytes.size() > 100) @(posedge i_clk);
        hold_sender = 1'b1;
        while (link_if.valid || due_results.size() != 0) @(posedge i_clk);
        hold_sender = 1'b0;
        settle();

        // register writes in the middle of a frame
        make_frame(16'h0A0B, 4, FLAW_NONE);
        send_bytes(0, 8);
        settle();
        write_reg(REG_TAIL_FIRST, 32'h0000_003C);
        write_reg(REG_CRC_INIT, 32'h1234_5678);
        frame_bytes[frame_bytes.size() - 2] = 8'h3C;
        send_bytes(8, frame_bytes.size());
        send_frame(16'h0C0D, 3, FLAW_NONE);
        settle();

        // opposite extremes, msb-first crc
        write_reg(REG_HEAD_FIRST, 32'h0000_0000);
        write_reg(REG_HEAD_SECOND, 32'h0000_00FF);
        write_reg(REG_TAIL_FIRST, 32'h0000_00FF);
        write_reg(REG_TAIL_SECOND, 32'h0000_0000);
        write_reg(REG_MAX_PAYLOAD, 32'd1);
        write_reg(REG_CRC_INIT, 32'h0000_0000);
        write_reg(REG_CRC_FINAL_XOR, 32'h0000_0000);
        write_reg(REG_CRC_REFLECTED, 32'd0);
        send_frame(16'hFFFF, 1, FLAW_NONE);
        send_bad_length(16'h0001, 16'd2);
        send_bad_length(16'h0002, 16'h0101);
        random_traffic(60);
        settle();

        // random settings, no stalls for the first half
        write_reg(REG_HEAD_FIRST, $urandom);
        write_reg(REG_HEAD_SECOND, $urandom);
        write_reg(REG_TAIL_FIRST, $urandom);
        write_reg(REG_TAIL_SECOND, $urandom);
        write_reg(REG_MAX_PAYLOAD, $urandom_range(2, 40));
        write_reg(REG_CRC_INIT, $urandom);
        write_reg(REG_CRC_FINAL_XOR, $urandom);
        write_reg(REG_CRC_REFLECTED, $urandom_range(1));
        steady = 1'b1;
        random_traffic(100);
        while (link_bytes.size() > 40) @(posedge i_clk);
        steady = 1'b0;
        settle();

        // equal head bytes, long frame
        write_reg(REG_HEAD_FIRST, 32'h0000_007E);
        write_reg(REG_HEAD_SECOND, 32'h0000_007E);
        write_reg(REG_MAX_PAYLOAD, 32'd512);
        write_reg(REG_CRC_INIT, 32'hFFFF_FFFF);
        write_reg(REG_CRC_FINAL_XOR, $urandom);
        write_reg(REG_CRC_REFLECTED, 32'd1);
        send_frame(16'h4D2B, 100, FLAW_NONE);
        send_bad_length(16'h4D2C, 16'd513);
        random_traffic(40);
        settle();

        repeat (8) @(posedge i_clk);
        if (due_results.size() != 0) report_fault("results still due at end of run");
        if (mismatches == 0) begin
            $display("** crc32_frame_receiver: PASSED **");
        end else begin
            $display("** crc32_frame_receiver: FAILED **");
        end
        $finish;
    end

endmodule
